### src/pwbt_pkg.sv
`timescale 1ns / 1ps
// pwbt_pkg: shared types, codes and constants of the pulse width bit transmitter
// used by every file under src; depends on nothing

package pwbt_pkg;

  // message store geometry
  localparam int MSG_DEPTH = 64;
  localparam int MSG_AW    = (MSG_DEPTH > 1) ? $clog2(MSG_DEPTH) : 1;
  localparam int MSG_CW    = $clog2(MSG_DEPTH + 1);

  localparam int OP_W      = 2;
  localparam int BYTE_W    = 8;
  localparam int BIT_IDX_W = 4;
  localparam int TP_W      = 2;
  localparam int CFG_AW    = 4;
  localparam int CFG_DW    = 32;

  // item op codes
  localparam logic [OP_W-1:0] OP_LOAD  = 2'd0;
  localparam logic [OP_W-1:0] OP_START = 2'd1;
  localparam logic [OP_W-1:0] OP_TICK  = 2'd2;

  // configuration register indexes (byte address bits [3:2])
  localparam logic [1:0] REG_PRE_PATTERN = 2'd0;
  localparam logic [1:0] REG_PRE_LENGTH  = 2'd1;
  localparam logic [1:0] REG_LEAD_HIGH   = 2'd2;
  localparam logic [1:0] REG_LEAD_LOW    = 2'd3;

  // reset values of the registers
  localparam logic [7:0]           RST_PRE_PATTERN = 8'd13;
  localparam logic [BIT_IDX_W-1:0] RST_PRE_LENGTH  = 4'd6;
  localparam logic [7:0]           RST_LEAD_HIGH   = 8'd3;
  localparam logic [7:0]           RST_LEAD_LOW    = 8'd3;

  localparam logic [BIT_IDX_W-1:0] PRE_MAX   = 4'd8;
  localparam logic [BIT_IDX_W-1:0] BYTE_BITS = 4'd8;
  localparam logic [TP_W-1:0]      TP_LAST   = 2'd2;

  typedef enum logic [2:0] {
    MODE_IDLE   = 3'd0,
    MODE_LEADH  = 3'd1,
    MODE_LEADL  = 3'd2,
    MODE_PRE    = 3'd3,
    MODE_MSG    = 3'd4,
    MODE_CLOSE  = 3'd5,
    MODE_FINISH = 3'd6
  } mode_t;

  typedef struct packed {
    logic [7:0]           preamble_pattern;
    logic [BIT_IDX_W-1:0] preamble_length;
    logic [7:0]           lead_high_ticks;
    logic [7:0]           lead_low_ticks;
  } cfg_t;

  typedef struct packed {
    logic              wr_en;
    logic [MSG_AW-1:0] wr_addr;
    logic [BYTE_W-1:0] wr_data;
    logic [MSG_AW-1:0] rd_addr;
  } mem_req_t;

  typedef struct packed {
    logic line_level;
    logic busy_res;
    logic load_error;
    logic done_res;
  } res_t;

endpackage

### src/pwbt_ifs.sv
`timescale 1ns / 1ps
// pwbt_in_if / pwbt_out_if: valid-ready channels for items and results
// depends on pwbt_pkg for field widths

interface pwbt_in_if import pwbt_pkg::*;;
  logic              valid;
  logic              ready;
  logic [OP_W-1:0]   op;
  logic [BYTE_W-1:0] data_byte;

  modport source (output valid, output op, output data_byte, input ready);
  modport sink   (input valid, input op, input data_byte, output ready);
endinterface

interface pwbt_out_if;
  logic valid;
  logic ready;
  logic line_level;
  logic busy_res;
  logic load_error;
  logic done_res;

  modport source (output valid, output line_level, output busy_res, output load_error,
                  output done_res, input ready);
  modport sink   (input valid, input line_level, input busy_res, input load_error,
                  input done_res, output ready);
endinterface

### src/pwbt_cfg_regs.sv
`timescale 1ns / 1ps
// pwbt_cfg_regs: apb-style register file for preamble and lead timing
// depends on pwbt_pkg

module pwbt_cfg_regs import pwbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [CFG_AW-1:0] paddr,
  input  logic [CFG_DW-1:0] pwdata,
  output logic [CFG_DW-1:0] prdata,
  output logic              pready,
  output cfg_t              cfg
);

  cfg_t cfg_r;
  cfg_t cfg_nxt;
  logic wr_beat;

  assign pready  = 1'b1;
  assign wr_beat = psel && penable && pwrite;
  assign cfg     = cfg_r;

  always_comb begin
    cfg_nxt = cfg_r;
    if (wr_beat) begin
      case (paddr[3:2])
        REG_PRE_PATTERN: cfg_nxt.preamble_pattern = pwdata[7:0];
        REG_PRE_LENGTH:  cfg_nxt.preamble_length  = pwdata[BIT_IDX_W-1:0];
        REG_LEAD_HIGH:   cfg_nxt.lead_high_ticks  = pwdata[7:0];
        REG_LEAD_LOW:    cfg_nxt.lead_low_ticks   = pwdata[7:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      REG_PRE_PATTERN: prdata = {24'd0, cfg_r.preamble_pattern};
      REG_PRE_LENGTH:  prdata = {28'd0, cfg_r.preamble_length};
      REG_LEAD_HIGH:   prdata = {24'd0, cfg_r.lead_high_ticks};
      REG_LEAD_LOW:    prdata = {24'd0, cfg_r.lead_low_ticks};
      default:         prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.preamble_pattern <= RST_PRE_PATTERN;
      cfg_r.preamble_length  <= RST_PRE_LENGTH;
      cfg_r.lead_high_ticks  <= RST_LEAD_HIGH;
      cfg_r.lead_low_ticks   <= RST_LEAD_LOW;
    end else begin
      cfg_r <= cfg_nxt;
    end
  end

endmodule

### src/pwbt_msg_mem.sv
`timescale 1ns / 1ps
// pwbt_msg_mem: message byte store, one write and one registered read a cycle
// depends on pwbt_pkg

module pwbt_msg_mem import pwbt_pkg::*; (
  input  logic              clk,
  input  mem_req_t          req,
  output logic [BYTE_W-1:0] rd_data
);

  logic [BYTE_W-1:0] mem [MSG_DEPTH];
  logic [BYTE_W-1:0] rd_data_r;

  assign rd_data = rd_data_r;

  always_ff @(posedge clk) begin
    if (req.wr_en) begin
      mem[req.wr_addr] <= req.wr_data;
    end
  end

  // write-through so the read register never shows a stale byte
  always_ff @(posedge clk) begin
    if (req.wr_en && (req.wr_addr == req.rd_addr)) begin
      rd_data_r <= req.wr_data;
    end else begin
      rd_data_r <= mem[req.rd_addr];
    end
  end

endmodule

### src/pwbt_seq.sv
`timescale 1ns / 1ps
// pwbt_seq: transmit sequencer; lead, preamble, message and closing phases
// depends on pwbt_pkg; reads bytes from pwbt_msg_mem through a prefetched read port

module pwbt_seq import pwbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              item_acc,
  input  logic [OP_W-1:0]   op,
  input  logic [BYTE_W-1:0] data_byte,
  input  cfg_t              cfg,
  input  logic [BYTE_W-1:0] rd_data,
  output mem_req_t          mem_req,
  output res_t              res
);

  mode_t                mode_r, mode_nxt;
  logic [MSG_CW-1:0]    count_r, count_nxt;
  logic [MSG_CW-1:0]    ri_r, ri_nxt;
  logic [BYTE_W-1:0]    sb_r, sb_nxt;
  logic [BIT_IDX_W-1:0] bi_r, bi_nxt;
  logic [TP_W-1:0]      tp_r, tp_nxt;
  logic [7:0]           lc_r, lc_nxt;
  logic                 cb_r, cb_nxt;
  logic                 line_r, line_nxt;

  mode_t                eff_mode;
  logic [7:0]           eff_lc;
  logic [BIT_IDX_W-1:0] eff_bi;
  logic [TP_W-1:0]      eff_tp;
  logic [TP_W-1:0]      tp_adv;
  logic [BIT_IDX_W-1:0] pre_len;
  logic [BIT_IDX_W-1:0] bits_v;
  logic [BYTE_W-1:0]    byte_v;
  logic [2:0]           pre_sel;
  logic                 more_bytes;
  logic                 tick_act;
  logic                 load_err;

  assign pre_len    = (cfg.preamble_length > PRE_MAX) ? PRE_MAX : cfg.preamble_length;
  assign more_bytes = (ri_r < count_r) && (ri_r < MSG_CW'(MSG_DEPTH));
  assign tick_act   = item_acc && (op == OP_TICK) && (mode_r != MODE_IDLE);
  assign tp_adv     = (eff_tp == TP_LAST) ? '0 : eff_tp + TP_W'(1);

  // phases with nothing to send fall through within the same tick
  always_comb begin
    eff_mode = mode_r;
    eff_lc   = lc_r;
    eff_bi   = bi_r;
    eff_tp   = tp_r;
    if (eff_mode == MODE_LEADH && eff_lc == '0) begin
      eff_mode = MODE_LEADL;
      eff_lc   = cfg.lead_low_ticks;
    end
    if (eff_mode == MODE_LEADL && eff_lc == '0) begin
      eff_mode = MODE_PRE;
      eff_bi   = pre_len;
      eff_tp   = '0;
    end
    if (eff_mode == MODE_PRE && eff_tp == '0 && eff_bi == '0) begin
      eff_mode = MODE_MSG;
    end
    if (eff_mode == MODE_MSG && eff_tp == '0 && eff_bi == '0 && !more_bytes) begin
      eff_mode = MODE_CLOSE;
    end
  end

  // next state
  always_comb begin
    mode_nxt  = mode_r;
    count_nxt = count_r;
    ri_nxt    = ri_r;
    sb_nxt    = sb_r;
    bi_nxt    = bi_r;
    tp_nxt    = tp_r;
    lc_nxt    = lc_r;
    cb_nxt    = cb_r;
    bits_v    = eff_bi;
    byte_v    = sb_r;
    pre_sel   = 3'(eff_bi - BIT_IDX_W'(1));
    mem_req.wr_en   = 1'b0;
    mem_req.wr_addr = count_r[MSG_AW-1:0];
    mem_req.wr_data = data_byte;
    if (item_acc) begin
      case (op)
        OP_LOAD: begin
          if (mode_r == MODE_IDLE && count_r < MSG_CW'(MSG_DEPTH)) begin
            mem_req.wr_en = 1'b1;
            count_nxt     = count_r + MSG_CW'(1);
          end
        end
        OP_START: begin
          if (mode_r == MODE_IDLE) begin
            mode_nxt = MODE_LEADH;
            lc_nxt   = cfg.lead_high_ticks;
            ri_nxt   = '0;
            bi_nxt   = '0;
            tp_nxt   = '0;
            sb_nxt   = '0;
            cb_nxt   = 1'b0;
          end
        end
        OP_TICK: begin
          if (mode_r != MODE_IDLE) begin
            mode_nxt = eff_mode;
            lc_nxt   = eff_lc;
            bi_nxt   = eff_bi;
            tp_nxt   = eff_tp;
            case (eff_mode)
              MODE_LEADH, MODE_LEADL: lc_nxt = eff_lc - 8'd1;
              MODE_PRE: begin
                if (eff_tp == '0) begin
                  bi_nxt = eff_bi - BIT_IDX_W'(1);
                  cb_nxt = cfg.preamble_pattern[pre_sel];
                end
                tp_nxt = tp_adv;
              end
              MODE_MSG: begin
                if (eff_tp == '0) begin
                  if (eff_bi == '0) begin
                    byte_v = rd_data;
                    ri_nxt = ri_r + MSG_CW'(1);
                    bits_v = BYTE_BITS;
                  end
                  cb_nxt = byte_v[BYTE_W-1];
                  sb_nxt = {byte_v[BYTE_W-2:0], 1'b0};
                  bi_nxt = bits_v - BIT_IDX_W'(1);
                end
                tp_nxt = tp_adv;
              end
              MODE_CLOSE: mode_nxt = MODE_FINISH;
              MODE_FINISH: begin
                mode_nxt  = MODE_IDLE;
                count_nxt = '0;
                ri_nxt    = '0;
              end
              default: mode_nxt = MODE_IDLE;
            endcase
          end
        end
        default: ;
      endcase
    end
    // keep the read register loaded with the byte at the next read index
    mem_req.rd_addr = ri_nxt[MSG_AW-1:0];
  end

  // outputs
  always_comb begin
    line_nxt = line_r;
    load_err = item_acc && (op == OP_LOAD) &&
               ((mode_r != MODE_IDLE) || (count_r >= MSG_CW'(MSG_DEPTH)));
    if (tick_act) begin
      case (eff_mode)
        MODE_LEADH: line_nxt = 1'b1;
        MODE_LEADL: line_nxt = 1'b0;
        MODE_PRE, MODE_MSG: begin
          case (eff_tp)
            2'd0:    line_nxt = 1'b1;
            2'd1:    line_nxt = cb_r;
            default: line_nxt = 1'b0;
          endcase
        end
        MODE_CLOSE: line_nxt = 1'b1;
        default:    line_nxt = 1'b0;
      endcase
    end
    res.line_level = line_nxt;
    res.busy_res   = (mode_nxt != MODE_IDLE);
    res.load_error = load_err;
    res.done_res   = tick_act && (eff_mode == MODE_FINISH);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      mode_r  <= MODE_IDLE;
      count_r <= '0;
      ri_r    <= '0;
      sb_r    <= '0;
      bi_r    <= '0;
      tp_r    <= '0;
      lc_r    <= '0;
      cb_r    <= 1'b0;
      line_r  <= 1'b0;
    end else begin
      mode_r  <= mode_nxt;
      count_r <= count_nxt;
      ri_r    <= ri_nxt;
      sb_r    <= sb_nxt;
      bi_r    <= bi_nxt;
      tp_r    <= tp_nxt;
      lc_r    <= lc_nxt;
      cb_r    <= cb_nxt;
      line_r  <= line_nxt;
    end
  end

endmodule

### src/pulse_width_bit_transmitter.sv
`timescale 1ns / 1ps
// pulse_width_bit_transmitter: top level; one result beat per item beat
// latency: the result of an item is on the output register the cycle after its beat
// throughput: one item a cycle unless output stalls; prefetch lets no tick wait
// reset: synchronous active-low rst_n clears the sequencer, output valid and the
// registers to their defaults; the message store itself is not cleared
// depends on pwbt_pkg, pwbt_ifs, pwbt_cfg_regs, pwbt_msg_mem, pwbt_seq

module pulse_width_bit_transmitter import pwbt_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  pwbt_in_if.sink           in_bus,
  pwbt_out_if.source        out_bus,
  input  logic              cfg_psel,
  input  logic              cfg_penable,
  input  logic              cfg_pwrite,
  input  logic [CFG_AW-1:0] cfg_paddr,
  input  logic [CFG_DW-1:0] cfg_pwdata,
  output logic [CFG_DW-1:0] cfg_prdata,
  output logic              cfg_pready
);

  cfg_t              cfg;
  mem_req_t          mem_req;
  logic [BYTE_W-1:0] rd_data;
  res_t              res;
  res_t              out_res_r;
  logic              out_valid_r;
  logic              item_acc;

  assign in_bus.ready = !out_valid_r || out_bus.ready;
  assign item_acc     = in_bus.valid && in_bus.ready;

  pwbt_cfg_regs u_cfg (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  pwbt_msg_mem u_mem (
    .clk     (clk),
    .req     (mem_req),
    .rd_data (rd_data)
  );

  pwbt_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .item_acc  (item_acc),
    .op        (in_bus.op),
    .data_byte (in_bus.data_byte),
    .cfg       (cfg),
    .rd_data   (rd_data),
    .mem_req   (mem_req),
    .res       (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (item_acc) begin
      out_valid_r <= 1'b1;
    end else if (out_bus.ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (item_acc) begin
      out_res_r <= res;
    end
  end

  assign out_bus.valid      = out_valid_r;
  assign out_bus.line_level = out_res_r.line_level;
  assign out_bus.busy_res   = out_res_r.busy_res;
  assign out_bus.load_error = out_res_r.load_error;
  assign out_bus.done_res   = out_res_r.done_res;

endmodule

### src/pwbt_checker.sv
`timescale 1ns / 1ps
// pwbt_checker: port-level checks of the transmitter, bound to the top level
// depends on pwbt_pkg and pulse_width_bit_transmitter

module pwbt_checker import pwbt_pkg::*; (
  input logic            clk,
  input logic            rst_n,
  input logic            in_valid,
  input logic            in_ready,
  input logic [OP_W-1:0] in_op,
  input logic            out_valid,
  input logic            out_ready,
  input logic            out_line_level,
  input logic            out_busy_res,
  input logic            out_load_error,
  input logic            out_done_res
);

  // a stalled result beat keeps its payload
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_line_level) &&
      $stable(out_busy_res) && $stable(out_load_error) && $stable(out_done_res))
    else $error("result beat changed while stalled");

  // the end of a transmission leaves the line low and the block idle
  a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_done_res |-> !out_busy_res && !out_line_level)
    else $error("done reported with line high or still busy");

  // every accepted non-load beat shows up next cycle unflagged; only loads can be refused
  a_next_result: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_op != OP_LOAD) |=> out_valid && !out_load_error)
    else $error("non-load beat missing or flagged as load error");

  // single output slot: no intake while a result is stuck
  a_no_overrun: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |-> !in_ready)
    else $error("input taken with output register full");

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid after reset");

endmodule

bind pulse_width_bit_transmitter pwbt_checker u_pwbt_checker (
  .clk            (clk),
  .rst_n          (rst_n),
  .in_valid       (in_bus.valid),
  .in_ready       (in_bus.ready),
  .in_op          (in_bus.op),
  .out_valid      (out_bus.valid),
  .out_ready      (out_bus.ready),
  .out_line_level (out_bus.line_level),
  .out_busy_res   (out_bus.busy_res),
  .out_load_error (out_bus.load_error),
  .out_done_res   (out_bus.done_res)
);

### verif/pulse_width_bit_transmitter_test.sv
`timescale 1ns / 1ps
// pulse_width_bit_transmitter_test: self-checking bench for the pulse width bit transmitter
// drives item beats and apb register accesses, predicts every result beat and compares
// depends on pwbt_pkg, pwbt_ifs and the pulse_width_bit_transmitter rtl

module pulse_width_bit_transmitter_test;
  import pwbt_pkg::*;

  // the op code that the block leaves unused
  localparam logic [OP_W-1:0] OP_NOP = 2'd3;
  localparam int RANDOM_ITEMS = 150;
  localparam int DRAIN_LIMIT  = 20000;

  logic              clk = 1'b0;
  logic              rst_n;
  logic              cfg_psel;
  logic              cfg_penable;
  logic              cfg_pwrite;
  logic [CFG_AW-1:0] cfg_paddr;
  logic [CFG_DW-1:0] cfg_pwdata;
  logic [CFG_DW-1:0] cfg_prdata;
  logic              cfg_pready;

  pwbt_in_if  in_ch ();
  pwbt_out_if out_ch ();

  pulse_width_bit_transmitter dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_bus     (in_ch),
    .out_bus    (out_ch),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // transmitter state as the bench sees it
  cfg_t                 cfg_now;
  mode_t                tx_mode;
  logic [BYTE_W-1:0]    msg_mem [MSG_DEPTH];
  int                   msg_count;
  int                   rd_idx;
  logic [BYTE_W-1:0]    shift_q;
  logic [7:0]           lead_cnt;
  logic [BIT_IDX_W-1:0] bits_left;
  logic [TP_W-1:0]      phase;
  logic                 cur_bit;
  logic                 line_q;

  res_t expected_line_q [$];

  int n_errors  = 0;
  int n_items   = 0;
  int n_results = 0;
  int n_done    = 0;
  int n_refused = 0;
  int n_writes  = 0;

  bit tx_steady   = 1'b0;
  bit rx_steady   = 1'b0;
  int rx_hold_req = 0;

  function automatic int pick_gap();
    if ($urandom_range(0, 99) < 90) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // one tick of the three-tick bit cell
  function automatic void emit_cell();
    case (phase)
      2'd0:    line_q = 1'b1;
      2'd1:    line_q = cur_bit;
      default: line_q = 1'b0;
    endcase
    phase = (phase == TP_LAST) ? 2'd0 : phase + 2'd1;
  endfunction

  // advances the line by one tick, falling through empty phases; 1 when the message ends
  function automatic bit advance_tick();
    bit again;
    bit fin;
    again = 1'b1;
    fin   = 1'b0;
    while (again) begin
      again = 1'b0;
      case (tx_mode)
        MODE_LEADH: begin
          if (lead_cnt == 0) begin
            tx_mode  = MODE_LEADL;
            lead_cnt = cfg_now.lead_low_ticks;
            again    = 1'b1;
          end else begin
            lead_cnt--;
            line_q = 1'b1;
          end
        end
        MODE_LEADL: begin
          if (lead_cnt == 0) begin
            tx_mode   = MODE_PRE;
            bits_left = (cfg_now.preamble_length > PRE_MAX) ? PRE_MAX
                                                            : cfg_now.preamble_length;
            phase     = '0;
            again     = 1'b1;
          end else begin
            lead_cnt--;
            line_q = 1'b0;
          end
        end
        MODE_PRE: begin
          if (phase == 0 && bits_left == 0) begin
            tx_mode = MODE_MSG;
            again   = 1'b1;
          end else begin
            if (phase == 0) begin
              bits_left--;
              cur_bit = cfg_now.preamble_pattern[bits_left];
            end
            emit_cell();
          end
        end
        MODE_MSG: begin
          if (phase == 0 && bits_left == 0) begin
            if (rd_idx < msg_count) begin
              shift_q   = msg_mem[rd_idx];
              rd_idx++;
              bits_left = BYTE_BITS;
            end else begin
              tx_mode = MODE_CLOSE;
              again   = 1'b1;
            end
          end
          if (!again) begin
            if (phase == 0) begin
              cur_bit = shift_q[BYTE_W-1];
              shift_q = {shift_q[BYTE_W-2:0], 1'b0};
              bits_left--;
            end
            emit_cell();
          end
        end
        MODE_CLOSE: begin
          line_q  = 1'b1;
          tx_mode = MODE_FINISH;
        end
        MODE_FINISH: begin
          line_q    = 1'b0;
          tx_mode   = MODE_IDLE;
          msg_count = 0;
          rd_idx    = 0;
          fin       = 1'b1;
        end
        default: begin
          tx_mode = MODE_IDLE;
          line_q  = 1'b0;
        end
      endcase
    end
    return fin;
  endfunction

  // result of one accepted item beat
  function automatic res_t next_line_state(input logic [OP_W-1:0] op,
                                           input logic [BYTE_W-1:0] data);
    res_t r;
    logic refused;
    logic fin;
    refused = 1'b0;
    fin     = 1'b0;
    case (op)
      OP_LOAD: begin
        if (tx_mode != MODE_IDLE || msg_count >= MSG_DEPTH) begin
          refused = 1'b1;
        end else begin
          msg_mem[msg_count] = data;
          msg_count++;
        end
      end
      OP_START: begin
        if (tx_mode == MODE_IDLE) begin
          tx_mode   = MODE_LEADH;
          lead_cnt  = cfg_now.lead_high_ticks;
          rd_idx    = 0;
          bits_left = '0;
          phase     = '0;
          shift_q   = '0;
          cur_bit   = 1'b0;
        end
      end
      OP_TICK: begin
        if (tx_mode != MODE_IDLE) fin = advance_tick();
      end
      default: ;
    endcase
    n_refused += int'(refused);
    n_done    += int'(fin);
    r.line_level = line_q;
    r.busy_res   = (tx_mode != MODE_IDLE);
    r.load_error = refused;
    r.done_res   = fin;
    return r;
  endfunction

  function automatic logic [CFG_DW-1:0] reg_value(input logic [1:0] idx);
    logic [CFG_DW-1:0] v;
    v = '0;
    case (idx)
      REG_PRE_PATTERN: v[7:0]           = cfg_now.preamble_pattern;
      REG_PRE_LENGTH:  v[BIT_IDX_W-1:0] = cfg_now.preamble_length;
      REG_LEAD_HIGH:   v[7:0]           = cfg_now.lead_high_ticks;
      REG_LEAD_LOW:    v[7:0]           = cfg_now.lead_low_ticks;
      default: ;
    endcase
    return v;
  endfunction

  task automatic check_field(input string name, input logic want, input logic got);
    if (got !== want) begin
      $display("%0t: %s mismatch, expected %0b, actual %0b", $time, name, want, got);
      n_errors++;
    end
  endtask

  // sends one item beat, after a random gap unless the sender is steady, and records what it should produce
  task automatic send_item(input logic [OP_W-1:0] op, input logic [BYTE_W-1:0] data);
    int gap;
    gap = (tx_steady || $urandom_range(0, 99) < 60) ? 0 : pick_gap();
    if (gap > 0) begin
      in_ch.valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_ch.valid     <= 1'b1;
    in_ch.op        <= op;
    in_ch.data_byte <= data;
    do @(posedge clk); while (!in_ch.ready);
    expected_line_q.push_back(next_line_state(op, data));
    n_items++;
  endtask

  // sender holds off until every result beat is back or the wait limit runs out
  task automatic drain();
    int waited;
    waited = 0;
    in_ch.valid <= 1'b0;
    while (expected_line_q.size() > 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk);
      waited++;
    end
    repeat (2) @(posedge clk);
  endtask

  task automatic finish_tx();
    while (tx_mode != MODE_IDLE) send_item(OP_TICK, 8'($urandom_range(0, 255)));
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [CFG_DW-1:0] value);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b1;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= value;
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
    case (idx)
      REG_PRE_PATTERN: cfg_now.preamble_pattern = value[7:0];
      REG_PRE_LENGTH:  cfg_now.preamble_length  = value[BIT_IDX_W-1:0];
      REG_LEAD_HIGH:   cfg_now.lead_high_ticks  = value[7:0];
      REG_LEAD_LOW:    cfg_now.lead_low_ticks   = value[7:0];
      default: ;
    endcase
    n_writes++;
  endtask

  task automatic read_reg(input logic [1:0] idx);
    logic [CFG_DW-1:0] want;
    want = reg_value(idx);
    cfg_psel    <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    @(posedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    if (cfg_prdata !== want) begin
      $display("%0t: register %0d read mismatch, expected %h, actual %h",
               $time, idx, want, cfg_prdata);
      n_errors++;
    end
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    @(posedge clk);
  endtask

  // registers only change with no message on the line and nothing in flight
  task automatic apply_config(input logic [CFG_DW-1:0] pattern, input logic [CFG_DW-1:0] len,
                              input logic [CFG_DW-1:0] high, input logic [CFG_DW-1:0] low);
    finish_tx();
    drain();
    write_reg(REG_PRE_PATTERN, pattern);
    write_reg(REG_PRE_LENGTH, len);
    write_reg(REG_LEAD_HIGH, high);
    write_reg(REG_LEAD_LOW, low);
    read_reg(REG_PRE_PATTERN);
    read_reg(REG_PRE_LENGTH);
    read_reg(REG_LEAD_HIGH);
    read_reg(REG_LEAD_LOW);
  endtask

  // loads, start, then ticks to the end with stray loads, starts and unused ops mixed in
  task automatic run_message(input int n_bytes, input int noise_pct);
    logic [OP_W-1:0] op;
    for (int i = 0; i < n_bytes; i++) send_item(OP_LOAD, 8'($urandom_range(0, 255)));
    send_item(OP_START, 8'($urandom_range(0, 255)));
    while (tx_mode != MODE_IDLE) begin
      if ($urandom_range(0, 99) >= noise_pct) begin
        op = OP_TICK;
      end else begin
        case ($urandom_range(0, 2))
          0:       op = OP_LOAD;
          1:       op = OP_START;
          default: op = OP_NOP;
        endcase
      end
      send_item(op, 8'($urandom_range(0, 255)));
    end
  endtask

  task automatic random_config();
    logic [CFG_DW-1:0] v [4];
    if ($urandom_range(0, 9) == 0) v[0] = $urandom_range(0, 1) ? 32'hFF : 32'h00;
    else v[0] = $urandom_range(0, 255);
    v[1] = $urandom_range(0, 15);
    v[2] = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 24);
    v[3] = ($urandom_range(0, 99) < 85) ? $urandom_range(0, 4) : $urandom_range(5, 24);
    // unused upper bits now and then, they must not stick
    for (int i = 0; i < 4; i++) begin
      if ($urandom_range(0, 3) == 0) v[i] = v[i] | ($urandom << 16);
    end
    apply_config(v[0], v[1], v[2], v[3]);
  endtask

  task automatic test_reset_registers();
    read_reg(REG_PRE_PATTERN);
    read_reg(REG_PRE_LENGTH);
    read_reg(REG_LEAD_HIGH);
    read_reg(REG_LEAD_LOW);
  endtask

  task automatic test_idle_items();
    send_item(OP_TICK, 8'hFF);
    send_item(OP_NOP, 8'h00);
  endtask

  // no leads, no preamble, nothing stored: closing tick then done straight away
  task automatic test_empty_message();
    apply_config(32'h00, 0, 0, 0);
    send_item(OP_START, 8'h00);
    send_item(OP_START, 8'hFF);
    send_item(OP_NOP, 8'hFF);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
    send_item(OP_TICK, 8'h00);
  endtask

  task automatic test_one_byte();
    send_item(OP_LOAD, 8'hFF);
    send_item(OP_START, 8'h00);
    send_item(OP_LOAD, 8'h00);
    send_item(OP_START, 8'hFF);
    finish_tx();
  endtask

  // fill every entry, overflow it, then send the lot with a saturated preamble
  task automatic test_store_full();
    apply_config(32'hFF, 12, 1, 1);
    for (int i = 0; i < MSG_DEPTH; i++) begin
      send_item(OP_LOAD, (i == 0) ? 8'h00 : (i == 1) ? 8'hFF : 8'($urandom_range(0, 255)));
    end
    send_item(OP_LOAD, 8'hFF);
    send_item(OP_LOAD, 8'h00);
    send_item(OP_NOP, 8'h5A);
    send_item(OP_START, 8'h00);
    finish_tx();
  endtask

  task automatic test_long_leads();
    apply_config(32'hA5, 8, 255, 255);
    run_message(1, 3);
  endtask

  // receiver stalls for a long stretch while the sender keeps offering items
  task automatic test_back_pressure();
    apply_config(32'h2D, 5, 2, 3);
    tx_steady   = 1'b1;
    rx_hold_req = 150;
    run_message(2, 0);
    tx_steady = 1'b0;
    drain();
  endtask

  task automatic test_drain_pause();
    for (int i = 0; i < 3; i++) send_item(OP_LOAD, 8'($urandom_range(0, 255)));
    send_item(OP_START, 8'($urandom_range(0, 255)));
    repeat (12) send_item(OP_TICK, 8'($urandom_range(0, 255)));
    drain();
    finish_tx();
  endtask

  task automatic test_steady_stream();
    tx_steady = 1'b1;
    rx_steady = 1'b1;
    run_message(3, 5);
    run_message(0, 5);
    tx_steady = 1'b0;
    rx_steady = 1'b0;
  endtask

  task automatic test_random_traffic();
    int first;
    int k;
    first = n_items;
    while (n_items - first < RANDOM_ITEMS) begin
      if ($urandom_range(0, 99) < 35) random_config();
      k = $urandom_range(0, 99);
      if (k < 8) begin
        // stray items with no message armed
        repeat ($urandom_range(1, 3))
          send_item((k < 4) ? OP_TICK : OP_NOP, 8'($urandom_range(0, 255)));
      end else if (k < 20) begin
        run_message(0, 5);
      end else if (k < 85) begin
        run_message($urandom_range(1, 3), 5);
      end else begin
        run_message($urandom_range(4, 12), 5);
      end
    end
  endtask

  // result side: random stalls, plus long hold-offs on request
  initial begin : result_sink
    int stall_left;
    stall_left = 0;
    out_ch.ready <= 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      @(posedge clk);
      if (rx_hold_req > 0) begin
        stall_left  = rx_hold_req;
        rx_hold_req = 0;
      end else if (stall_left == 0 && !rx_steady && $urandom_range(0, 99) < 15) begin
        stall_left = pick_gap();
      end
      if (stall_left > 0) begin
        out_ch.ready <= 1'b0;
        stall_left--;
      end else begin
        out_ch.ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin : result_check
    res_t want;
    if (rst_n === 1'b1 && out_ch.valid === 1'b1 && out_ch.ready === 1'b1) begin
      n_results++;
      if (expected_line_q.size() == 0) begin
        $display("%0t: result beat with none expected, actual line %0b busy %0b err %0b done %0b",
                 $time, out_ch.line_level, out_ch.busy_res, out_ch.load_error,
                 out_ch.done_res);
        n_errors++;
      end else begin
        want = expected_line_q.pop_front();
        check_field("line_level", want.line_level, out_ch.line_level);
        check_field("busy_res", want.busy_res, out_ch.busy_res);
        check_field("load_error", want.load_error, out_ch.load_error);
        check_field("done_res", want.done_res, out_ch.done_res);
      end
    end
  end

  initial begin
    #30_000_000;
    $display("%0t: run timed out", $time);
    $display("** pulse_width_bit_transmitter: FAILED **");
    $finish;
  end

  initial begin
    rst_n           <= 1'b0;
    in_ch.valid     <= 1'b0;
    in_ch.op        <= OP_LOAD;
    in_ch.data_byte <= '0;
    cfg_psel        <= 1'b0;
    cfg_penable     <= 1'b0;
    cfg_pwrite      <= 1'b0;
    cfg_paddr       <= '0;
    cfg_pwdata      <= '0;
    cfg_now.preamble_pattern = RST_PRE_PATTERN;
    cfg_now.preamble_length  = RST_PRE_LENGTH;
    cfg_now.lead_high_ticks  = RST_LEAD_HIGH;
    cfg_now.lead_low_ticks   = RST_LEAD_LOW;
    tx_mode   = MODE_IDLE;
    msg_count = 0;
    rd_idx    = 0;
    shift_q   = '0;
    lead_cnt  = '0;
    bits_left = '0;
    phase     = '0;
    cur_bit   = 1'b0;
    line_q    = 1'b0;
    repeat (11) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_reset_registers();
    test_idle_items();
    test_empty_message();
    test_one_byte();
    test_store_full();
    test_long_leads();
    test_back_pressure();
    test_drain_pause();
    test_steady_stream();
    test_random_traffic();

    drain();
    repeat (4) @(posedge clk);
    if (expected_line_q.size() != 0) begin
      $display("%0t: %0d expected result beats never arrived", $time, expected_line_q.size());
      n_errors++;
    end
    $display("covered %0d item beats, %0d result beats, %0d messages to done, %0d refused loads",
             n_items, n_results, n_done, n_refused);
    $display("plus %0d register writes, a full store, 255-tick leads and long receiver stalls",
             n_writes);
    if (n_errors == 0) begin
      $display("** pulse_width_bit_transmitter: PASSED **");
    end else begin
      $display("** pulse_width_bit_transmitter: FAILED **");
    end
    $finish;
  end

endmodule
